[hdl/swsr_pkg.sv]
package swsr_pkg;

	localparam int unsigned TICK_W  = 12;
	localparam int unsigned SHORT_W = 8;
	localparam int unsigned BYTES_W = 4;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 12;

	localparam logic [CFG_IDX_W-1:0] REG_START_LOW   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_HIGH  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RESP_FIRST  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RESP_SECOND = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BIT_DELAY   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BYTES       = 3'd5;

	localparam logic [TICK_W-1:0]  START_LOW_RST   = 12'd1200;
	localparam logic [SHORT_W-1:0] START_HIGH_RST  = 8'd20;
	localparam logic [SHORT_W-1:0] RESP_FIRST_RST  = 8'd40;
	localparam logic [SHORT_W-1:0] RESP_SECOND_RST = 8'd80;
	localparam logic [SHORT_W-1:0] BIT_DELAY_RST   = 8'd40;
	localparam logic [BYTES_W-1:0] BYTES_RST       = 4'd5;

	localparam logic [2:0] BIT_LAST = 3'd7;

	localparam logic [1:0] STATUS_PENDING  = 2'd0;
	localparam logic [1:0] STATUS_OK       = 2'd1;
	localparam logic [1:0] STATUS_NOT_LOW  = 2'd2;
	localparam logic [1:0] STATUS_NOT_HIGH = 2'd3;

	typedef struct packed {
		logic [TICK_W-1:0]  start_low_ticks;
		logic [SHORT_W-1:0] start_high_ticks;
		logic [SHORT_W-1:0] response_first_wait;
		logic [SHORT_W-1:0] response_second_wait;
		logic [SHORT_W-1:0] bit_sample_delay;
		logic [BYTES_W-1:0] bytes_to_read;
	} cfg_t;

	typedef struct packed {
		logic       drive_enable;
		logic       drive_level;
		logic [1:0] response_status;
		logic       byte_ready;
		logic [7:0] byte_value;
		logic       last_byte;
		logic       busy_res;
	} res_t;

endpackage

[hdl/swsr_cfg.sv]
module swsr_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_en,
	input  logic [swsr_pkg::CFG_IDX_W-1:0]     wr_index,
	input  logic [swsr_pkg::CFG_DATA_W-1:0]    wr_data,
	output swsr_pkg::cfg_t                     cfg
);

	swsr_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_low_ticks      <= swsr_pkg::START_LOW_RST;
			cfg_q.start_high_ticks     <= swsr_pkg::START_HIGH_RST;
			cfg_q.response_first_wait  <= swsr_pkg::RESP_FIRST_RST;
			cfg_q.response_second_wait <= swsr_pkg::RESP_SECOND_RST;
			cfg_q.bit_sample_delay     <= swsr_pkg::BIT_DELAY_RST;
			cfg_q.bytes_to_read        <= swsr_pkg::BYTES_RST;
		end else if (wr_en) begin
			case (wr_index)
				swsr_pkg::REG_START_LOW: begin
					cfg_q.start_low_ticks <= wr_data[swsr_pkg::TICK_W-1:0];
				end
				swsr_pkg::REG_START_HIGH: begin
					cfg_q.start_high_ticks <= wr_data[swsr_pkg::SHORT_W-1:0];
				end
				swsr_pkg::REG_RESP_FIRST: begin
					cfg_q.response_first_wait <= wr_data[swsr_pkg::SHORT_W-1:0];
				end
				swsr_pkg::REG_RESP_SECOND: begin
					cfg_q.response_second_wait <= wr_data[swsr_pkg::SHORT_W-1:0];
				end
				swsr_pkg::REG_BIT_DELAY: begin
					cfg_q.bit_sample_delay <= wr_data[swsr_pkg::SHORT_W-1:0];
				end
				swsr_pkg::REG_BYTES: begin
					cfg_q.bytes_to_read <= wr_data[swsr_pkg::BYTES_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[hdl/swsr_seq.sv]
module swsr_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  logic            start_request,
	input  logic            line_level,
	input  swsr_pkg::cfg_t  cfg,
	output swsr_pkg::res_t  res
);

	localparam logic [3:0] PH_IDLE     = 4'd0;
	localparam logic [3:0] PH_LOW      = 4'd1;
	localparam logic [3:0] PH_HIGH     = 4'd2;
	localparam logic [3:0] PH_RESP1    = 4'd3;
	localparam logic [3:0] PH_RESP2    = 4'd4;
	localparam logic [3:0] PH_WAITLOW  = 4'd5;
	localparam logic [3:0] PH_WAITHIGH = 4'd6;
	localparam logic [3:0] PH_SAMPLE   = 4'd7;
	localparam logic [3:0] PH_BITLOW   = 4'd8;

	logic [3:0]  phase_q, ph, n_ph;
	logic [11:0] tick_q, tc, tc_inc, n_tc;
	logic [2:0]  bit_q, bi, n_bi;
	logic [7:0]  shift_q, sb, n_sb, shifted;
	logic [3:0]  byte_q, bc, n_bc;
	logic [1:0]  status_q, st, n_st;

	always_comb begin
		ph = phase_q;
		tc = tick_q;
		bi = bit_q;
		sb = shift_q;
		bc = byte_q;
		st = status_q;
		if (start_request) begin
			ph = PH_LOW;
			tc = '0;
			bi = '0;
			sb = '0;
			bc = '0;
			st = swsr_pkg::STATUS_PENDING;
		end
	end

	assign tc_inc  = tc + 12'd1;
	assign shifted = {sb[6:0], line_level};

	always_comb begin
		n_ph = ph;
		n_tc = tc;
		n_bi = bi;
		n_sb = sb;
		n_bc = bc;
		n_st = st;
		res.drive_enable = 1'b0;
		res.drive_level  = 1'b0;
		res.byte_ready   = 1'b0;
		res.byte_value   = '0;
		res.last_byte    = 1'b0;
		res.busy_res     = (ph != PH_IDLE);
		case (ph)
			PH_LOW: begin
				res.drive_enable = 1'b1;
				n_tc = tc_inc;
				if (tc_inc >= cfg.start_low_ticks) begin
					n_ph = PH_HIGH;
					n_tc = '0;
				end
			end
			PH_HIGH: begin
				res.drive_enable = 1'b1;
				res.drive_level  = 1'b1;
				n_tc = tc_inc;
				if (tc_inc >= {4'd0, cfg.start_high_ticks}) begin
					n_ph = PH_RESP1;
					n_tc = '0;
				end
			end
			PH_RESP1: begin
				n_tc = tc_inc;
				if (tc_inc >= {4'd0, cfg.response_first_wait}) begin
					n_tc = '0;
					if (line_level) begin
						n_st = swsr_pkg::STATUS_NOT_LOW;
						n_ph = PH_IDLE;
					end else begin
						n_ph = PH_RESP2;
					end
				end
			end
			PH_RESP2: begin
				n_tc = tc_inc;
				if (tc_inc >= {4'd0, cfg.response_second_wait}) begin
					n_tc = '0;
					if (!line_level) begin
						n_st = swsr_pkg::STATUS_NOT_HIGH;
						n_ph = PH_IDLE;
					end else begin
						n_st = swsr_pkg::STATUS_OK;
						n_ph = PH_WAITLOW;
					end
				end
			end
			PH_WAITLOW: begin
				if (!line_level) begin
					n_ph = PH_WAITHIGH;
				end
			end
			PH_WAITHIGH: begin
				if (line_level) begin
					n_ph = PH_SAMPLE;
					n_tc = '0;
				end
			end
			PH_SAMPLE: begin
				n_tc = tc_inc;
				if (tc_inc >= {4'd0, cfg.bit_sample_delay}) begin
					n_tc = '0;
					n_sb = shifted;
					n_ph = line_level ? PH_BITLOW : PH_WAITHIGH;
					if (bi == swsr_pkg::BIT_LAST) begin
						n_bi = '0;
						res.byte_ready = 1'b1;
						res.byte_value = shifted;
						n_sb = '0;
						if (({1'b0, bc} + 5'd1) >= {1'b0, cfg.bytes_to_read}) begin
							res.last_byte = 1'b1;
							n_bc = '0;
							n_ph = PH_IDLE;
						end else begin
							n_bc = bc + 4'd1;
						end
					end else begin
						n_bi = bi + 3'd1;
					end
				end
			end
			PH_BITLOW: begin
				if (!line_level) begin
					n_ph = PH_WAITHIGH;
				end
			end
			default: begin
				n_ph = PH_IDLE;
			end
		endcase
		res.response_status = n_st;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			tick_q   <= '0;
			bit_q    <= '0;
			shift_q  <= '0;
			byte_q   <= '0;
			status_q <= swsr_pkg::STATUS_PENDING;
		end else if (step) begin
			phase_q  <= n_ph;
			tick_q   <= n_tc;
			bit_q    <= n_bi;
			shift_q  <= n_sb;
			byte_q   <= n_bc;
			status_q <= n_st;
		end
	end

	a_drive_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res.drive_enable |-> res.busy_res)
		else $error("line driven outside a transaction");

	a_last_ready: assert property (@(posedge clk) disable iff (!arst_n)
		res.last_byte |-> res.byte_ready)
		else $error("last byte flagged without a byte");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.last_byte |=> phase_q == PH_IDLE && byte_q == 4'd0)
		else $error("sequencer not idle after the final byte");

	a_byte_bits: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.byte_ready |=> bit_q == 3'd0 && shift_q == 8'd0)
		else $error("bit assembly not cleared after a byte");

	a_fail_idle: assert property (@(posedge clk) disable iff (!arst_n)
		step && !start_request && (status_q == swsr_pkg::STATUS_PENDING)
		&& ((n_st == swsr_pkg::STATUS_NOT_LOW) || (n_st == swsr_pkg::STATUS_NOT_HIGH))
		|=> phase_q == PH_IDLE)
		else $error("response failure did not abort");

endmodule

[hdl/single_wire_sensor_reader.sv]
// Single-wire sensor reader, advanced by one microsecond tick per input transaction.
// Each input transaction carries start_request and the sampled line_level; each one
// yields exactly one output transaction with the line drive (drive_enable,
// drive_level), the response status, an optional received byte and busy_res.
// A start request drives the line low, then high, releases it, checks the sensor
// response and, if it is good, assembles bytes_to_read bytes (at least one), MSB first.
// Both channels use valid/stall; a transaction moves when valid is high and stall
// is low. An input transaction is registered in the input register, stepped through
// the sequencer and its result registered in the output register. One transaction
// per clock is sustained while the receiver does not stall; the rate is set by the
// step of the sequencer between the input and output registers.
// When the receiver stalls, the result is held and, if the input register is empty,
// one further input transaction is still taken into it; after that in_stall rises
// until the output is taken.
// Configuration writes (cfg_valid/cfg_ready, always ready) are for the user to make while
// idle; the block does not enforce this. Reset empties both registers, loads the
// default timing values and leaves the sequencer idle with status pending.
module single_wire_sensor_reader (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [11:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        start_request,
	input  logic        line_level,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        drive_enable,
	output logic        drive_level,
	output logic [1:0]  response_status,
	output logic        byte_ready,
	output logic [7:0]  byte_value,
	output logic        last_byte,
	output logic        busy_res
);

	swsr_pkg::cfg_t cfg;
	swsr_pkg::res_t res, res_s2;

	logic valid_s1, start_s1, level_s1;
	logic valid_s2;
	logic adv, step, accept;

	assign cfg_ready = 1'b1;

	swsr_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	assign adv      = !valid_s2 || !out_stall;
	assign step     = valid_s1 && adv;
	assign in_stall = valid_s1 && !adv;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			start_s1 <= start_request;
			level_s1 <= line_level;
		end
	end

	swsr_seq u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.start_request (start_s1),
		.line_level    (level_s1),
		.cfg           (cfg),
		.res           (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (step) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_s2 <= res;
		end
	end

	assign out_valid       = valid_s2;
	assign drive_enable    = res_s2.drive_enable;
	assign drive_level     = res_s2.drive_level;
	assign response_status = res_s2.response_status;
	assign byte_ready      = res_s2.byte_ready;
	assign byte_value      = res_s2.byte_value;
	assign last_byte       = res_s2.last_byte;
	assign busy_res        = res_s2.busy_res;

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2 && out_stall)
		else $error("input stalled with room in the pipeline");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && out_stall |=> valid_s2 && $stable(res_s2))
		else $error("stalled result lost or changed");

	a_step_moves: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> valid_s2)
		else $error("processed transaction not presented");

endmodule

[dv/single_wire_sensor_reader_tb.sv]
module single_wire_sensor_reader_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [3:0] {
		L_IDLE,
		L_DRIVE_LOW,
		L_DRIVE_HIGH,
		L_RESP_FIRST,
		L_RESP_SECOND,
		L_WAIT_LOW,
		L_WAIT_HIGH,
		L_SAMPLE,
		L_BIT_LOW
	} line_phase_t;

	typedef struct packed {
		logic start;
		logic level;
		logic typed;
		swsr_pkg::res_t want;
	} tick_row_t;

	localparam swsr_pkg::res_t R_IDLE      = '0;
	localparam swsr_pkg::res_t R_LOW       = '{1'b1, 1'b0, swsr_pkg::STATUS_PENDING, 1'b0,
		8'h00, 1'b0, 1'b1};
	localparam swsr_pkg::res_t R_HIGH      = '{1'b1, 1'b1, swsr_pkg::STATUS_PENDING, 1'b0,
		8'h00, 1'b0, 1'b1};
	localparam swsr_pkg::res_t R_FAIL_LOW  = '{1'b0, 1'b0, swsr_pkg::STATUS_NOT_LOW, 1'b0,
		8'h00, 1'b0, 1'b1};
	localparam swsr_pkg::res_t R_HELD_LOW  = '{1'b0, 1'b0, swsr_pkg::STATUS_NOT_LOW, 1'b0,
		8'h00, 1'b0, 1'b0};
	localparam swsr_pkg::res_t R_FAIL_HIGH = '{1'b0, 1'b0, swsr_pkg::STATUS_NOT_HIGH, 1'b0,
		8'h00, 1'b0, 1'b1};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [11:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic        start_request;
	logic        line_level;
	logic        out_valid;
	logic        out_stall;
	logic        drive_enable;
	logic        drive_level;
	logic [1:0]  response_status;
	logic        byte_ready;
	logic [7:0]  byte_value;
	logic        last_byte;
	logic        busy_res;

	line_phase_t ph = L_IDLE;
	logic [11:0] tick_cnt = '0;
	logic [2:0]  bit_pos = '0;
	logic [7:0]  shift_in = '0;
	logic [3:0]  byte_cnt = '0;
	logic [1:0]  status = swsr_pkg::STATUS_PENDING;
	swsr_pkg::cfg_t line_cfg = '{swsr_pkg::START_LOW_RST, swsr_pkg::START_HIGH_RST,
		swsr_pkg::RESP_FIRST_RST, swsr_pkg::RESP_SECOND_RST, swsr_pkg::BIT_DELAY_RST,
		swsr_pkg::BYTES_RST};

	swsr_pkg::res_t line_results_q[$];
	tick_row_t dir_rows [0:23];
	int        fail_mode = 0;
	bit        idle_on = 1'b1;
	bit        pressure_done = 1'b0;
	int        ticks_accepted = 0;
	int        starts_seen = 0;
	int        fails_seen = 0;
	int        bytes_seen = 0;
	int        bad_count = 0;

	single_wire_sensor_reader u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.start_request   (start_request),
		.line_level      (line_level),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.drive_enable    (drive_enable),
		.drive_level     (drive_level),
		.response_status (response_status),
		.byte_ready      (byte_ready),
		.byte_value      (byte_value),
		.last_byte       (last_byte),
		.busy_res        (busy_res)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic tick_hit(input logic [11:0] limit);
		tick_cnt = tick_cnt + 12'd1;
		return tick_cnt >= limit;
	endfunction

	// Advances the sequencer by one tick and returns the outputs of that tick.
	function automatic swsr_pkg::res_t sequence_tick(input logic s, input logic l);
		swsr_pkg::res_t r;
		r = '0;
		if (s) begin
			ph = L_DRIVE_LOW;
			tick_cnt = '0;
			bit_pos = '0;
			shift_in = '0;
			byte_cnt = '0;
			status = swsr_pkg::STATUS_PENDING;
		end
		r.busy_res = (ph != L_IDLE);
		case (ph)
			L_DRIVE_LOW: begin
				r.drive_enable = 1'b1;
				if (tick_hit(line_cfg.start_low_ticks)) begin
					ph = L_DRIVE_HIGH;
					tick_cnt = '0;
				end
			end
			L_DRIVE_HIGH: begin
				r.drive_enable = 1'b1;
				r.drive_level = 1'b1;
				if (tick_hit(line_cfg.start_high_ticks)) begin
					ph = L_RESP_FIRST;
					tick_cnt = '0;
				end
			end
			L_RESP_FIRST: begin
				if (tick_hit(line_cfg.response_first_wait)) begin
					tick_cnt = '0;
					if (l) begin
						status = swsr_pkg::STATUS_NOT_LOW;
						ph = L_IDLE;
						fails_seen++;
					end else begin
						ph = L_RESP_SECOND;
					end
				end
			end
			L_RESP_SECOND: begin
				if (tick_hit(line_cfg.response_second_wait)) begin
					tick_cnt = '0;
					if (!l) begin
						status = swsr_pkg::STATUS_NOT_HIGH;
						ph = L_IDLE;
						fails_seen++;
					end else begin
						status = swsr_pkg::STATUS_OK;
						ph = L_WAIT_LOW;
					end
				end
			end
			L_WAIT_LOW: begin
				if (!l)
					ph = L_WAIT_HIGH;
			end
			L_WAIT_HIGH: begin
				if (l) begin
					ph = L_SAMPLE;
					tick_cnt = '0;
				end
			end
			L_SAMPLE: begin
				if (tick_hit(line_cfg.bit_sample_delay)) begin
					tick_cnt = '0;
					shift_in = {shift_in[6:0], l};
					ph = l ? L_BIT_LOW : L_WAIT_HIGH;
					if (bit_pos == swsr_pkg::BIT_LAST) begin
						bit_pos = '0;
						r.byte_ready = 1'b1;
						r.byte_value = shift_in;
						shift_in = '0;
						if ({1'b0, byte_cnt} + 5'd1 >= {1'b0, line_cfg.bytes_to_read}) begin
							r.last_byte = 1'b1;
							byte_cnt = '0;
							ph = L_IDLE;
						end else begin
							byte_cnt = byte_cnt + 4'd1;
						end
					end else begin
						bit_pos = bit_pos + 3'd1;
					end
				end
			end
			L_BIT_LOW: begin
				if (!l)
					ph = L_WAIT_HIGH;
			end
			default: ph = L_IDLE;
		endcase
		r.response_status = status;
		return r;
	endfunction

	task automatic send_tick(input logic s, input logic l, output swsr_pkg::res_t r);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		start_request <= s;
		line_level <= l;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		r = sequence_tick(s, l);
		ticks_accepted++;
		if (s)
			starts_seen++;
	endtask

	task automatic play_rows(input int first, input int last);
		swsr_pkg::res_t r;
		for (int i = first; i <= last; i++) begin
			send_tick(dir_rows[i].start, dir_rows[i].level, r);
			line_results_q.push_back(dir_rows[i].typed ? dir_rows[i].want : r);
		end
	endtask

	// The line answers like a sensor that follows the sequencer. In noisy mode some
	// transactions fail their response, some are restarted, and a few levels flip.
	// A phase ends after its tick count, even in the middle of a transaction.
	task automatic run_phase(input int n_items, input bit noisy);
		int   counted;
		int   pick;
		logic s;
		logic l;
		swsr_pkg::res_t r;
		counted = 0;
		while (counted < n_items) begin
			s = 1'b0;
			if (ph == L_IDLE)
				s = ($urandom_range(0, 2) == 0);
			else if (noisy)
				s = ($urandom_range(0, 399) == 0);
			if (s) begin
				pick = $urandom_range(0, 9);
				fail_mode = !noisy ? 0 : (pick == 0) ? 1 : (pick == 1) ? 2 : 0;
			end
			case (ph)
				L_RESP_FIRST:         l = (fail_mode == 1);
				L_RESP_SECOND:        l = (fail_mode != 2);
				L_WAIT_LOW, L_BIT_LOW: l = ($urandom_range(0, 3) == 0);
				L_WAIT_HIGH:          l = ($urandom_range(0, 3) != 0);
				L_SAMPLE: begin
					if (int'(tick_cnt) + 1 >= int'(line_cfg.bit_sample_delay))
						l = 1'($urandom_range(0, 1));
					else
						l = 1'b1;
				end
				default:              l = 1'($urandom_range(0, 1));
			endcase
			if (noisy && $urandom_range(0, 49) == 0)
				l = ~l;
			send_tick(s, l, r);
			line_results_q.push_back(r);
			counted++;
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (line_results_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic load_config(input swsr_pkg::cfg_t c);
		logic [2:0]  idx [6];
		logic [11:0] val [6];
		logic [31:0] junk;
		junk = $urandom;
		idx = '{swsr_pkg::REG_START_LOW, swsr_pkg::REG_START_HIGH, swsr_pkg::REG_RESP_FIRST,
			swsr_pkg::REG_RESP_SECOND, swsr_pkg::REG_BIT_DELAY, swsr_pkg::REG_BYTES};
		val = '{c.start_low_ticks, {junk[3:0], c.start_high_ticks},
			{junk[7:4], c.response_first_wait}, {junk[11:8], c.response_second_wait},
			{junk[15:12], c.bit_sample_delay}, {junk[23:16], c.bytes_to_read}};
		for (int i = 0; i < 6; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			case (idx[i])
				swsr_pkg::REG_START_LOW:   line_cfg.start_low_ticks = val[i];
				swsr_pkg::REG_START_HIGH:  line_cfg.start_high_ticks = val[i][7:0];
				swsr_pkg::REG_RESP_FIRST:  line_cfg.response_first_wait = val[i][7:0];
				swsr_pkg::REG_RESP_SECOND: line_cfg.response_second_wait = val[i][7:0];
				swsr_pkg::REG_BIT_DELAY:   line_cfg.bit_sample_delay = val[i][7:0];
				swsr_pkg::REG_BYTES:       line_cfg.bytes_to_read = val[i][3:0];
				default: ;
			endcase
		end
		cfg_valid <= 1'b0;
	endtask

	function automatic swsr_pkg::cfg_t small_cfg();
		swsr_pkg::cfg_t c;
		c.start_low_ticks = 12'($urandom_range(0, 12));
		c.start_high_ticks = 8'($urandom_range(0, 5));
		c.response_first_wait = 8'($urandom_range(0, 6));
		c.response_second_wait = 8'($urandom_range(0, 6));
		c.bit_sample_delay = 8'($urandom_range(0, 6));
		if ($urandom_range(0, 7) == 0)
			c.bytes_to_read = 4'($urandom_range(9, 15));
		else
			c.bytes_to_read = 4'($urandom_range(0, 8));
		return c;
	endfunction

	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (!pressure_done && ticks_accepted >= 500) begin
				pressure_done = 1'b1;
				out_stall <= 1'b1;
				repeat (80) @(posedge clk);
				out_stall <= 1'b0;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : check_results
		swsr_pkg::res_t got;
		swsr_pkg::res_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = {drive_enable, drive_level, response_status, byte_ready, byte_value,
				last_byte, busy_res};
			if (got.byte_ready)
				bytes_seen++;
			if (line_results_q.size() == 0) begin
				bad_count++;
				if (bad_count <= 10)
					$display("%0t: result transaction with no tick pending", $realtime);
			end else begin
				want = line_results_q.pop_front();
				if (got !== want) begin
					bad_count++;
					if (bad_count <= 10)
						$display({"%0t: tick mismatch: expected en=%0b lvl=%0b st=%0d ",
							"rdy=%0b byte=%02h last=%0b busy=%0b, got en=%0b lvl=%0b ",
							"st=%0d rdy=%0b byte=%02h last=%0b busy=%0b"}, $realtime,
							want.drive_enable, want.drive_level, want.response_status,
							want.byte_ready, want.byte_value, want.last_byte, want.busy_res,
							got.drive_enable, got.drive_level, got.response_status,
							got.byte_ready, got.byte_value, got.last_byte, got.busy_res);
				end
			end
		end
	end

	initial begin
		#8_000_000;
		$display("single_wire_sensor_reader_tb: done, errors");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= swsr_pkg::REG_START_LOW;
		cfg_data <= '0;
		in_valid <= 1'b0;
		start_request <= 1'b0;
		line_level <= 1'b0;
		dir_rows = '{
			'{1'b0, 1'b0, 1'b1, R_IDLE},
			'{1'b0, 1'b1, 1'b1, R_IDLE},
			'{1'b1, 1'b1, 1'b1, R_LOW},
			'{1'b0, 1'b1, 1'b1, R_HIGH},
			'{1'b0, 1'b1, 1'b1, R_FAIL_LOW},
			'{1'b0, 1'b0, 1'b1, R_HELD_LOW},
			'{1'b1, 1'b0, 1'b1, R_LOW},
			'{1'b0, 1'b0, 1'b0, R_IDLE},
			'{1'b0, 1'b0, 1'b0, R_IDLE},
			'{1'b0, 1'b0, 1'b1, R_FAIL_HIGH},
			'{1'b1, 1'b1, 1'b0, R_IDLE},
			'{1'b0, 1'b1, 1'b0, R_IDLE},
			'{1'b1, 1'b0, 1'b1, R_LOW},
			'{1'b0, 1'b0, 1'b0, R_IDLE},
			'{1'b0, 1'b0, 1'b0, R_IDLE},
			'{1'b0, 1'b1, 1'b0, R_IDLE},
			'{1'b0, 1'b1, 1'b0, R_IDLE},
			'{1'b0, 1'b0, 1'b0, R_IDLE},
			'{1'b0, 1'b1, 1'b0, R_IDLE},
			'{1'b0, 1'b1, 1'b0, R_IDLE},
			'{1'b0, 1'b1, 1'b0, R_IDLE},
			'{1'b0, 1'b0, 1'b0, R_IDLE},
			'{1'b0, 1'b1, 1'b0, R_IDLE},
			'{1'b0, 1'b0, 1'b0, R_IDLE}
		};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Idle ticks, then the start of a transaction with the values loaded by reset.
		play_rows(0, 1);
		run_phase(40, 1'b0);
		drain();

		// Zero timing registers and a zero byte count act as one, so every rule
		// of the sequencer shows up within a few ticks.
		load_config('0);
		play_rows(2, 23);
		run_phase(100, 1'b1);
		drain();
		load_config('{12'd1, 8'd1, 8'd1, 8'd1, 8'd1, 4'd1});
		run_phase(120, 1'b1);
		repeat (4) begin
			drain();
			load_config(small_cfg());
			run_phase(100, 1'b1);
		end
		drain();
		load_config('{12'hFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 4'd1});
		run_phase(30, 1'b0);
		drain();
		load_config('{12'd2, 8'd1, 8'd2, 8'd2, 8'd3, 4'hF});
		run_phase(80, 1'b0);
		drain();
		idle_on = 1'b0;
		load_config(small_cfg());
		run_phase(150, 1'b1);
		drain();
		repeat (20) @(posedge clk);
		bad_count += line_results_q.size();

		$display("Run covered %0d ticks, %0d start requests, %0d response failures, %0d bytes.",
			ticks_accepted, starts_seen, fails_seen, bytes_seen);
		$display("Timing sets: reset values, all zero, all one, five random sets, maxima, 15 bytes.");
		if (bad_count == 0)
			$display("single_wire_sensor_reader_tb: done, clean");
		else
			$display("single_wire_sensor_reader_tb: done, errors");
		$finish;
	end

endmodule
